// File: src/b64d_pkg.sv
`timescale 1ns / 1ps
package b64d_pkg;

  localparam int unsigned MaxInDefault      = 256;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [7:0] CH_PAD   = 8'h3d;  // '='
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_SLASH = 8'h2f;  // '/'

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_first;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [7:0] byte_total;
    logic       end_of_run;
  } out_item_t;

  // All results caused by one accepted item.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    logic            has_status;
    logic            fail;
    logic [7:0]      total;
  } bundle_t;

  // {valid, value} of an alphabet character.
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == CH_PLUS) begin
      r = {1'b1, SEXTET_PLUS};
    end else if (c == CH_SLASH) begin
      r = {1'b1, SEXTET_SLASH};
    end
    return r;
  endfunction

endpackage

// File: src/b64d_front.sv
`timescale 1ns / 1ps
module b64d_front import b64d_pkg::*; #(
  parameter int unsigned MaxIn = MaxInDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     bundle_valid_o,
  output bundle_t  bundle_o
);

  localparam int unsigned CntW = $clog2(MaxIn + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_PLUS  = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [1:0]      gp_q, gp_d;
  logic [2:0][5:0] held_q, held_d;
  logic            twp_q, twp_d;
  logic [7:0]      dc_q, dc_d;
  logic [CntW-1:0] cc_q, cc_d;
  logic            failed_q, failed_d;

  logic            ok, do_body, pad, emit_status;
  logic [6:0]      sx;
  logic [1:0]      nb;
  logic [2:0][7:0] data;
  logic [8:0]      sum;

  assign sx  = sextet_of(item_i.char_in);
  assign pad = (item_i.char_in == CH_PAD);

  always_comb begin
    phase_d     = phase_q;
    gp_d        = gp_q;
    held_d      = held_q;
    twp_d       = twp_q;
    dc_d        = dc_q;
    cc_d        = cc_q;
    failed_d    = failed_q;
    ok          = 1'b1;
    do_body     = 1'b0;
    emit_status = 1'b0;
    nb          = 2'd0;
    data        = '0;
    sum         = 9'd0;

    // A first mark, or any item while idle, opens a new message.
    if (item_i.is_first || phase_q == PH_IDLE) begin
      phase_d  = PH_START;
      gp_d     = 2'd0;
      held_d   = '0;
      twp_d    = 1'b0;
      dc_d     = 8'd0;
      cc_d     = '0;
      failed_d = 1'b0;
    end

    if (failed_d) begin
      // Drop the rest of an aborted message.
      if (item_i.is_last) begin
        phase_d  = PH_IDLE;
        failed_d = 1'b0;
      end
    end else begin
      if (cc_d >= CntW'(MaxIn)) begin
        ok = 1'b0;
      end else begin
        cc_d = cc_d + 1'b1;
        case (phase_d)
          PH_START: begin
            if (item_i.char_in == CH_PLUS && !item_i.is_last) begin
              phase_d = PH_PLUS;
            end else begin
              phase_d = PH_BODY;
              do_body = 1'b1;
            end
          end
          PH_PLUS: begin
            phase_d = PH_BODY;
            // Held plus turns out to be data: it is the first sextet.
            if (item_i.char_in != CH_SPACE) begin
              held_d[0] = SEXTET_PLUS;
              gp_d      = 2'd1;
              do_body   = 1'b1;
            end
          end
          default: do_body = 1'b1;
        endcase

        if (do_body) begin
          case (gp_d)
            2'd0, 2'd1: begin
              if (!sx[6]) begin
                ok = 1'b0;
              end else begin
                held_d[gp_d[0]] = sx[5:0];
                gp_d            = gp_d + 2'd1;
              end
            end
            2'd2: begin
              if (pad) begin
                twp_d     = 1'b1;
                held_d[2] = 6'd0;
                gp_d      = 2'd3;
              end else if (!sx[6]) begin
                ok = 1'b0;
              end else begin
                twp_d     = 1'b0;
                held_d[2] = sx[5:0];
                gp_d      = 2'd3;
              end
            end
            default: begin
              if (!pad && !sx[6]) begin
                ok = 1'b0;
              end else begin
                data[0] = {held_d[0], held_d[1][5:4]};
                nb      = 2'd1;
                if (!twp_d) begin
                  data[1] = {held_d[1][3:0], held_d[2][5:2]};
                  nb      = 2'd2;
                  if (!pad) begin
                    data[2] = {held_d[2][1:0], sx[5:0]};
                    nb      = 2'd3;
                  end
                end
                gp_d  = 2'd0;
                twp_d = 1'b0;
              end
            end
          endcase
        end
      end

      if (!ok) begin
        emit_status = 1'b1;
        failed_d    = 1'b1;
      end
      if (item_i.is_last) begin
        if (ok) begin
          emit_status = 1'b1;
        end
        phase_d  = PH_IDLE;
        failed_d = 1'b0;
      end
    end

    // Saturating byte total.
    sum  = {1'b0, dc_d} + {7'd0, nb};
    dc_d = sum[8] ? 8'hff : sum[7:0];
  end

  assign bundle_valid_o      = (nb != 2'd0) || emit_status;
  assign bundle_o.data       = data;
  assign bundle_o.nbytes     = nb;
  assign bundle_o.has_status = emit_status;
  assign bundle_o.fail       = !ok;
  assign bundle_o.total      = ok ? dc_d : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      gp_q     <= 2'd0;
      held_q   <= '0;
      twp_q    <= 1'b0;
      dc_q     <= 8'd0;
      cc_q     <= '0;
      failed_q <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      gp_q     <= gp_d;
      held_q   <= held_d;
      twp_q    <= twp_d;
      dc_q     <= dc_d;
      cc_q     <= cc_d;
      failed_q <= failed_d;
    end
  end

endmodule

// File: src/b64d_queue.sv
`timescale 1ns / 1ps
module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  input  logic    pop_i,
  output bundle_t data_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: src/b64d_back.sv
`timescale 1ns / 1ps
module b64d_back import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      bundle_valid_i,
  input  bundle_t   bundle_i,
  output logic      bundle_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  bundle_t    cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  out_item_t  out_q;
  logic       out_valid_q;

  logic [2:0] n_res;
  logic [1:0] last_pos;
  logic       at_last, advance, load;
  out_item_t  res;

  assign n_res    = {1'b0, cur_q.nbytes} + {2'd0, cur_q.has_status};
  assign last_pos = 2'(n_res - 3'd1);
  assign at_last  = (idx_q == last_pos);
  assign advance  = cur_valid_q && (!out_valid_q || pop_i);
  assign load     = bundle_valid_i && (!cur_valid_q || (advance && at_last));
  assign bundle_pop_o = load;

  always_comb begin
    res            = '0;
    res.end_of_run = at_last;
    if (idx_q < cur_q.nbytes) begin
      res.kind = KIND_DATA;
      case (idx_q)
        2'd0:    res.out_byte = cur_q.data[0];
        2'd1:    res.out_byte = cur_q.data[1];
        default: res.out_byte = cur_q.data[2];
      endcase
    end else begin
      res.kind       = cur_q.fail ? KIND_FAIL : KIND_OK;
      res.byte_total = cur_q.total;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= bundle_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (advance) begin
        if (at_last) begin
          cur_valid_q <= 1'b0;
          idx_q       <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

// File: src/base64_stream_decoder.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake   | Payload
// ---------+-----------+-------------+-----------------------------------------
// input    | in        | push / full | in_item_i  (char_in, is_first, is_last)
// result   | out       | empty / pop | out_item_o (out_byte, kind, byte_total,
//          |           |             |             end_of_run)
//
// One character is taken per cycle while the queue is not full; the front decodes
// it in the cycle it is accepted and queues its results (up to three bytes and a
// status) as one entry. The back drains one result per cycle while results are
// popped, so a full group yields up to four results; the bundle queue depth sets
// how far the front runs ahead. Results pass the queue, cur_q and out_q in turn.
// Reset clears both sides and leaves the decoder idle, awaiting a message.
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int unsigned MAX_IN      = MaxInDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic    accept;
  logic    f_valid;
  bundle_t f_bundle;
  bundle_t q_bundle;
  logic    q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  b64d_front #(
    .MaxIn (MAX_IN)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (in_item_i),
    .bundle_valid_o (f_valid),
    .bundle_o       (f_bundle)
  );

  b64d_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && f_valid),
    .data_i  (f_bundle),
    .pop_i   (q_pop),
    .data_o  (q_bundle),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b64d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (!q_empty),
    .bundle_i       (q_bundle),
    .bundle_pop_o   (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_item_o     (out_item_o)
  );

endmodule

// File: src/b64d_checker.sv
`timescale 1ns / 1ps
module b64d_checker import b64d_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input in_item_t  in_item_i,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // Only data, ok and fail kinds ever leave the block.
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.kind == KIND_DATA || out_item_o.kind == KIND_OK ||
                out_item_o.kind == KIND_FAIL))
    else $error("unknown result kind");

  // A status closes the run of its item and carries no byte.
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind != KIND_DATA) |->
      (out_item_o.out_byte == 8'd0 && out_item_o.end_of_run))
    else $error("status result malformed");

  // Data bytes carry no total.
  a_data_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind == KIND_DATA) |-> out_item_o.byte_total == 8'd0)
    else $error("data byte with nonzero total");

  // Hold a result that is not taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_item_i  (in_item_i),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

// File: tb/sv/base64_stream_decoder_test.sv
`timescale 1ns / 1ps
module base64_stream_decoder_test;
  import b64d_pkg::*;

  localparam int MaxChars   = MaxInDefault;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 20;

  typedef enum logic [1:0] {MSG_IDLE, MSG_START, MSG_PLUS_HELD, MSG_BODY} msg_phase_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  in_item_t  char_q[$];
  out_item_t decoded_results_q[$];
  out_item_t step_out[$];

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // decoder state
  logic [5:0] held [3];
  logic [1:0] grp_pos;
  logic       third_pad;
  logic [7:0] dec_count;
  int         char_count;
  logic       failed;
  msg_phase_e msg_phase = MSG_IDLE;

  base64_stream_decoder uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int sextet_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == CH_PLUS) return int'(SEXTET_PLUS);
    if (c == CH_SLASH) return int'(SEXTET_SLASH);
    return -1;
  endfunction

  function automatic logic [7:0] alpha_char(int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    if (v == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic void emit(logic [7:0] b, logic [1:0] k, logic [7:0] total);
    out_item_t r;
    r.out_byte   = b;
    r.kind       = k;
    r.byte_total = total;
    r.end_of_run = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    emit(b, KIND_DATA, 8'd0);
    if (dec_count != 8'd255) dec_count++;
  endfunction

  function automatic void begin_message();
    held[0]    = '0;
    held[1]    = '0;
    held[2]    = '0;
    grp_pos    = '0;
    third_pad  = 1'b0;
    dec_count  = '0;
    char_count = 0;
    failed     = 1'b0;
    msg_phase  = MSG_START;
  endfunction

  // Returns 0 when the character aborts the message.
  function automatic bit take_sextet(logic [7:0] c);
    bit pad;
    int v;
    pad = (c == CH_PAD);
    v   = sextet_value(c);
    case (grp_pos)
      2'd0, 2'd1: begin
        if (v < 0) return 1'b0;
        held[grp_pos[0]] = 6'(v);
        grp_pos++;
      end
      2'd2: begin
        if (pad) begin
          third_pad = 1'b1;
          held[2]   = '0;
        end else begin
          if (v < 0) return 1'b0;
          third_pad = 1'b0;
          held[2]   = 6'(v);
        end
        grp_pos = 2'd3;
      end
      default: begin
        if (!pad && v < 0) return 1'b0;
        emit_byte({held[0], held[1][5:4]});
        if (!third_pad) begin
          emit_byte({held[1][3:0], held[2][5:2]});
          if (!pad) emit_byte({held[2][1:0], 6'(v)});
        end
        grp_pos   = '0;
        third_pad = 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void decode_char_item(in_item_t item);
    bit ok;
    out_item_t r;
    ok = 1'b1;
    step_out.delete();
    if (item.is_first || msg_phase == MSG_IDLE) begin_message();
    // an aborted message stays silent until its last mark
    if (failed) begin
      if (item.is_last) begin
        msg_phase = MSG_IDLE;
        failed    = 1'b0;
      end
      return;
    end
    if (char_count >= MaxChars) begin
      ok = 1'b0;
    end else begin
      char_count++;
      if (msg_phase == MSG_START) begin
        if (item.char_in == CH_PLUS && !item.is_last) begin
          msg_phase = MSG_PLUS_HELD;
        end else begin
          msg_phase = MSG_BODY;
          ok = take_sextet(item.char_in);
        end
      end else if (msg_phase == MSG_PLUS_HELD) begin
        msg_phase = MSG_BODY;
        // a held plus without a space after it is data
        if (item.char_in != CH_SPACE) begin
          ok = take_sextet(CH_PLUS);
          if (ok) ok = take_sextet(item.char_in);
        end
      end else begin
        ok = take_sextet(item.char_in);
      end
    end
    if (!ok) begin
      emit(8'd0, KIND_FAIL, 8'd0);
      failed = 1'b1;
    end
    if (item.is_last) begin
      if (ok) emit(8'd0, KIND_OK, dec_count);
      msg_phase = MSG_IDLE;
      failed    = 1'b0;
    end
    for (int i = 0; i < step_out.size(); i++) begin
      r = step_out[i];
      r.end_of_run = (i == step_out.size() - 1);
      decoded_results_q.push_back(r);
    end
  endfunction

  // Driver: hold the item until taken, then pick the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) decode_char_item(in_item);
      if (!push || !full) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push    <= 1'b1;
          in_item <= char_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (decoded_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
          mismatch_count++;
        end else begin
          want = decoded_results_q.pop_front();
          check_field("out_byte", want.out_byte, out_item.out_byte);
          check_field("kind", want.kind, out_item.kind);
          check_field("byte_total", want.byte_total, out_item.byte_total);
          check_field("end_of_run", want.end_of_run, out_item.end_of_run);
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic add_char(logic [7:0] c, bit first, bit last);
    in_item_t item;
    item.char_in  = c;
    item.is_first = first;
    item.is_last  = last;
    char_q.push_back(item);
  endtask

  task automatic add_text(string s, bit first, bit last);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i], first && i == 0, last && i == s.len() - 1);
    end
  endtask

  // Mostly well-formed messages with random content; some are corrupted.
  task automatic add_random_message();
    logic [7:0] text[$];
    int pad_sel;
    bit first_mark;
    bit last_mark;
    if ($urandom_range(3) == 0) begin
      text.push_back(CH_PLUS);
      text.push_back(CH_SPACE);
    end
    repeat ($urandom_range(3)) begin
      pad_sel = $urandom_range(6);
      text.push_back(alpha_char($urandom_range(63)));
      text.push_back(alpha_char($urandom_range(63)));
      text.push_back((pad_sel == 0 || pad_sel == 2) ? CH_PAD : alpha_char($urandom_range(63)));
      text.push_back((pad_sel <= 1) ? CH_PAD : alpha_char($urandom_range(63)));
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(alpha_char($urandom_range(63)));
    end
    if (text.size() == 0) text.push_back(alpha_char($urandom_range(63)));
    if ($urandom_range(4) == 0) begin
      text[$urandom_range(text.size() - 1)] =
          ($urandom_range(2) == 0) ? CH_PAD : 8'($urandom_range(255));
    end
    for (int i = 0; i < text.size(); i++) begin
      first_mark = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
      last_mark  = (i == text.size() - 1) && ($urandom_range(19) != 0);
      add_char(text[i], first_mark, last_mark);
    end
  endtask

  task automatic fill_random(int n);
    int target;
    target = char_q.size() + n;
    while (char_q.size() < target) begin
      if ($urandom_range(99) < 85) begin
        add_random_message();
      end else begin
        add_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_accepted();
    do @(negedge clk_i); while (char_q.size() != 0 || push);
  endtask

  task automatic wait_drained();
    while (decoded_results_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_text("+ TWFu", 1'b1, 1'b1);
    add_text("QU", 1'b1, 1'b0);        // dropped by the next first mark
    add_text("QUI=", 1'b1, 1'b1);
    add_text("QQ=A", 1'b0, 1'b1);      // starts without a first mark
    add_text("+/==", 1'b1, 1'b1);      // plus not followed by a space is data
    add_text("+", 1'b1, 1'b1);
    add_text("=A", 1'b1, 1'b1);        // pad in the first slot aborts
    add_char(8'h00, 1'b1, 1'b1);
    add_char(8'hff, 1'b1, 1'b1);
    add_text("+ ", 1'b1, 1'b1);        // empty body
    wait_accepted();
    // hold off until the decoder has drained
    wait_drained();

    fill_random(30);
    wait_accepted();

    send_idle_pct = 84;
    fill_random(30);
    wait_accepted();

    send_idle_pct = 0;
    pop_stall_pct = 84;
    fill_random(30);
    wait_accepted();

    send_idle_pct = 8;
    pop_stall_pct = 8;
    fill_random(30);
    wait_accepted();

    wait_drained();
    repeat (DrainWait) @(negedge clk_i);
    if (mismatch_count == 0 && decoded_results_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
